// File: rtl/obb_pair_overlap_test_unit_defines.svh
// ----------------------------------------------------------------------------
// obb pair overlap test unit assertion macros
// shared property shapes for the port level checker
// ----------------------------------------------------------------------------
`ifndef OBB_PAIR_OVERLAP_TEST_UNIT_DEFINES_SVH
`define OBB_PAIR_OVERLAP_TEST_UNIT_DEFINES_SVH

// implication checked at every edge outside reset
`define OBB_OVL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// plain condition checked at every edge outside reset
`define OBB_OVL_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

// File: rtl/obb_ovl_pkg.sv
// ----------------------------------------------------------------------------
// obb overlap package
// shared types, angle constants and the quarter wave sine generator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package obb_ovl_pkg;

  localparam int unsigned TRIG_FRAC_BITS_DEF = 16;

  localparam logic [12:0] QUARTER_TURN = 13'd1440;
  localparam logic [12:0] HALF_TURN    = 13'd2880;
  localparam logic [12:0] THREE_QTURN  = 13'd4320;
  localparam logic [12:0] FULL_TURN    = 13'd5760;
  localparam int unsigned ROM_DEPTH    = 1441;

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

  // raw box fields as they arrive
  typedef struct packed {
    logic signed [23:0] cx;
    logic signed [23:0] cy;
    logic [23:0]        w;
    logic [23:0]        h;
    logic [12:0]        ang;
  } box_raw_t;

  // centre in q.9, half extents in q.9 (equal to the q16.8 size)
  typedef struct packed {
    logic signed [24:0] cx;
    logic signed [24:0] cy;
    logic [23:0]        hx;
    logic [23:0]        hy;
  } box_geo_t;

  typedef struct packed {
    logic [10:0] idx;
    logic        neg;
  } trig_idx_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // sine of r/16 degree over a quarter wave, taylor to x^11 in q30
  function automatic logic [63:0] quarter_sin(input logic [10:0] r, input int unsigned fb);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    x  = ({53'd0, r} * PI_Q30 + 64'd1440) / 64'd2880;
    x2 = (x * x + (64'd1 << 29)) >> 30;
    t  = ONE_Q30 - x2 / 64'd110;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    s  = (s + (64'd1 << (29 - fb))) >> (30 - fb);
    if (s > (64'd1 << fb)) begin
      s = 64'd1 << fb;
    end
    return s;
  endfunction

endpackage

// File: rtl/obb_ovl_queue.sv
// ----------------------------------------------------------------------------
// obb overlap queue
// two entry fifo between the trig front end and the geometry back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module obb_ovl_queue #(
  parameter int unsigned W = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic [W-1:0]         data_i,
  input  logic                 pop_i,
  output logic [W-1:0]         data_o,
  output obb_ovl_pkg::q_stat_t stat_o
);

  logic [W-1:0] mem_q [2];
  logic         wr_ptr_q, wr_ptr_d;
  logic         rd_ptr_q, rd_ptr_d;
  logic [1:0]   cnt_q, cnt_d;
  logic         do_push, do_pop;

  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign data_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: rtl/obb_ovl_front.sv
// ----------------------------------------------------------------------------
// obb overlap front end
// angle wrap, quadrant fold, sine table lookup and sign fix for both boxes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module obb_ovl_front #(
  parameter int unsigned TrigFracBits = obb_ovl_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  obb_ovl_pkg::box_raw_t          box_i [2],
  input  obb_ovl_pkg::q_stat_t           q_stat_i,
  output logic                           push_o,
  output obb_ovl_pkg::box_geo_t          geo_o [2],
  output logic signed [TrigFracBits+1:0] cos_o [2],
  output logic signed [TrigFracBits+1:0] sin_o [2]
);

  localparam int unsigned TW = TrigFracBits + 2;

  typedef logic [TrigFracBits:0] rom_t [obb_ovl_pkg::ROM_DEPTH];

  function automatic rom_t build_rom();
    rom_t        r;
    logic [63:0] v;
    for (int i = 0; i < obb_ovl_pkg::ROM_DEPTH; i++) begin
      v    = obb_ovl_pkg::quarter_sin(11'(i), TrigFracBits);
      r[i] = v[TrigFracBits:0];
    end
    return r;
  endfunction

  // fold a wrapped angle onto the quarter wave
  function automatic obb_ovl_pkg::trig_idx_t fold(input logic [12:0] a);
    obb_ovl_pkg::trig_idx_t t;
    priority if (a < obb_ovl_pkg::QUARTER_TURN) begin
      t.idx = a[10:0];
      t.neg = 1'b0;
    end else if (a < obb_ovl_pkg::HALF_TURN) begin
      t.idx = 11'(obb_ovl_pkg::HALF_TURN - a);
      t.neg = 1'b0;
    end else if (a < obb_ovl_pkg::THREE_QTURN) begin
      t.idx = 11'(a - obb_ovl_pkg::HALF_TURN);
      t.neg = 1'b1;
    end else begin
      t.idx = 11'(obb_ovl_pkg::FULL_TURN - a);
      t.neg = 1'b1;
    end
    return t;
  endfunction

  // one copy per box, two read ports each
  localparam rom_t RomA = build_rom();
  localparam rom_t RomB = build_rom();

  logic                   en;
  logic                   v0_q, v1_q, v2_q, v3_q;
  obb_ovl_pkg::box_geo_t  geo0_q [2], geo1_q [2], geo2_q [2], geo3_q [2];
  logic [12:0]            am0_q [2];
  logic [12:0]            cam [2];
  obb_ovl_pkg::trig_idx_t sidx_q [2], cidx_q [2];
  logic [TrigFracBits:0]  srom_q [2], crom_q [2];
  logic                   sneg_q [2], cneg_q [2];
  logic signed [TW-1:0]   c3_q [2], s3_q [2];

  assign en     = !(v3_q && q_stat_i.full);
  assign busy_o = !en;
  assign push_o = v3_q && !q_stat_i.full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v0_q <= start_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_comb begin
    for (int b = 0; b < 2; b++) begin
      cam[b] = (am0_q[b] >= obb_ovl_pkg::THREE_QTURN) ?
               am0_q[b] - obb_ovl_pkg::THREE_QTURN :
               am0_q[b] + obb_ovl_pkg::QUARTER_TURN;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int b = 0; b < 2; b++) begin
        geo0_q[b].cx <= {box_i[b].cx, 1'b0};
        geo0_q[b].cy <= {box_i[b].cy, 1'b0};
        geo0_q[b].hx <= box_i[b].w;
        geo0_q[b].hy <= box_i[b].h;
        am0_q[b]     <= (box_i[b].ang >= obb_ovl_pkg::FULL_TURN) ?
                        box_i[b].ang - obb_ovl_pkg::FULL_TURN : box_i[b].ang;
        geo1_q[b]    <= geo0_q[b];
        sidx_q[b]    <= fold(am0_q[b]);
        cidx_q[b]    <= fold(cam[b]);
        geo2_q[b]    <= geo1_q[b];
        sneg_q[b]    <= sidx_q[b].neg;
        cneg_q[b]    <= cidx_q[b].neg;
        geo3_q[b]    <= geo2_q[b];
        s3_q[b]      <= sneg_q[b] ? -$signed({1'b0, srom_q[b]}) : $signed({1'b0, srom_q[b]});
        c3_q[b]      <= cneg_q[b] ? -$signed({1'b0, crom_q[b]}) : $signed({1'b0, crom_q[b]});
      end
      srom_q[0] <= RomA[sidx_q[0].idx];
      crom_q[0] <= RomA[cidx_q[0].idx];
      srom_q[1] <= RomB[sidx_q[1].idx];
      crom_q[1] <= RomB[cidx_q[1].idx];
    end
  end

  assign geo_o = geo3_q;
  assign cos_o = c3_q;
  assign sin_o = s3_q;

endmodule

// File: rtl/obb_ovl_back.sv
// ----------------------------------------------------------------------------
// obb overlap back end
// corners, bounding box reject, projections on four axes and gap test
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module obb_ovl_back #(
  parameter int unsigned TrigFracBits = obb_ovl_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  obb_ovl_pkg::box_geo_t          geo_i [2],
  input  logic signed [TrigFracBits+1:0] cos_i [2],
  input  logic signed [TrigFracBits+1:0] sin_i [2],
  output logic                           done_o,
  output logic                           overlapping_o
);

  localparam int unsigned F   = TrigFracBits;
  localparam int unsigned TW  = F + 2;
  localparam int unsigned PRW = TW + 25;
  localparam int unsigned VW  = PRW + 1;
  localparam int unsigned PXW = 27;
  localparam int unsigned AW  = F + 28;
  localparam int unsigned MW  = TW + PXW;
  localparam int unsigned PW  = MW + 1;

  logic [6:0] v_q;

  // stage 0: rotated half extents
  logic signed [PRW-1:0] chx_q [2], shy_q [2], chy_q [2], shx_q [2];
  logic signed [24:0]    cx0_q [2], cy0_q [2], cx1_q [2], cy1_q [2];
  logic signed [TW-1:0]  c_q [3][2], s_q [3][2];
  // stage 1: corner offsets before rounding, bounding extents
  logic signed [VW-1:0]  vx_q [2][4], vy_q [2][4];
  logic [VW-1:0]         ex_q [2], ey_q [2];
  // stage 2: corners and reject
  logic signed [PXW-1:0] px_q [2][4], py_q [2][4];
  logic                  rej_q [4];
  // stage 3..5: projections
  logic signed [MW-1:0]  mx_q [4][2][4], my_q [4][2][4];
  logic signed [PW-1:0]  p_q [4][2][4];
  logic signed [PW-1:0]  mn_q [4][2], mxv_q [4][2];
  logic                  ovl_q;

  logic signed [VW-1:0]  rx [2][4], ry [2][4];
  logic signed [AW-1:0]  hix [2], lox [2], hiy [2], loy [2];
  logic signed [TW-1:0]  axx [4], axy [4];
  logic signed [PW-1:0]  lo01, lo23, hi01, hi23;
  logic signed [PW-1:0]  mn_d [4][2], mx_d [4][2];
  logic                  sep;

  function automatic logic signed [VW-1:0] rnd(input logic signed [VW-1:0] v);
    logic [VW-1:0] mag;
    logic [VW-1:0] r;
    mag = v[VW-1] ? VW'(-v) : VW'(v);
    r   = (mag + (VW'(1) << (F - 1))) >> F;
    return v[VW-1] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic [VW-1:0] absv(input logic signed [PRW-1:0] v);
    return v[PRW-1] ? VW'(-v) : VW'(v);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[5:0], valid_i};
    end
  end

  always_comb begin
    for (int b = 0; b < 2; b++) begin
      for (int i = 0; i < 4; i++) begin
        rx[b][i] = rnd(vx_q[b][i]);
        ry[b][i] = rnd(vy_q[b][i]);
      end
      hix[b] = (AW'(cx1_q[b]) <<< F) + $signed(AW'(ex_q[b]));
      lox[b] = (AW'(cx1_q[b]) <<< F) - $signed(AW'(ex_q[b]));
      hiy[b] = (AW'(cy1_q[b]) <<< F) + $signed(AW'(ey_q[b]));
      loy[b] = (AW'(cy1_q[b]) <<< F) - $signed(AW'(ey_q[b]));
    end
    // axes in the order b, b+90, a, a+90
    axx[0] = c_q[2][1];
    axy[0] = -s_q[2][1];
    axx[1] = -s_q[2][1];
    axy[1] = -c_q[2][1];
    axx[2] = c_q[2][0];
    axy[2] = -s_q[2][0];
    axx[3] = -s_q[2][0];
    axy[3] = -c_q[2][0];
    sep = 1'b0;
    for (int k = 0; k < 4; k++) begin
      for (int b = 0; b < 2; b++) begin
        lo01 = (p_q[k][b][1] < p_q[k][b][0]) ? p_q[k][b][1] : p_q[k][b][0];
        lo23 = (p_q[k][b][3] < p_q[k][b][2]) ? p_q[k][b][3] : p_q[k][b][2];
        hi01 = (p_q[k][b][1] > p_q[k][b][0]) ? p_q[k][b][1] : p_q[k][b][0];
        hi23 = (p_q[k][b][3] > p_q[k][b][2]) ? p_q[k][b][3] : p_q[k][b][2];
        mn_d[k][b] = (lo23 < lo01) ? lo23 : lo01;
        mx_d[k][b] = (hi23 > hi01) ? hi23 : hi01;
      end
      if (mxv_q[k][0] < mn_q[k][1] || mxv_q[k][1] < mn_q[k][0]) begin
        sep = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int b = 0; b < 2; b++) begin
      // stage 0
      chx_q[b] <= cos_i[b] * $signed({1'b0, geo_i[b].hx});
      shy_q[b] <= sin_i[b] * $signed({1'b0, geo_i[b].hy});
      chy_q[b] <= cos_i[b] * $signed({1'b0, geo_i[b].hy});
      shx_q[b] <= sin_i[b] * $signed({1'b0, geo_i[b].hx});
      cx0_q[b] <= geo_i[b].cx;
      cy0_q[b] <= geo_i[b].cy;
      c_q[0][b] <= cos_i[b];
      s_q[0][b] <= sin_i[b];
      // stage 1, corner order (-,-) (+,-) (+,+) (-,+)
      for (int i = 0; i < 4; i++) begin
        vx_q[b][i] <= ((i == 0 || i == 3) ? -VW'(chx_q[b]) : VW'(chx_q[b]))
                    + ((i < 2) ? -VW'(shy_q[b]) : VW'(shy_q[b]));
        vy_q[b][i] <= ((i < 2) ? -VW'(chy_q[b]) : VW'(chy_q[b]))
                    - ((i == 0 || i == 3) ? -VW'(shx_q[b]) : VW'(shx_q[b]));
      end
      ex_q[b]  <= absv(chx_q[b]) + absv(shy_q[b]);
      ey_q[b]  <= absv(shx_q[b]) + absv(chy_q[b]);
      cx1_q[b] <= cx0_q[b];
      cy1_q[b] <= cy0_q[b];
      // stage 2
      for (int i = 0; i < 4; i++) begin
        px_q[b][i] <= PXW'(VW'(cx1_q[b]) + rx[b][i]);
        py_q[b][i] <= PXW'(VW'(cy1_q[b]) + ry[b][i]);
      end
    end
    for (int s = 1; s < 3; s++) begin
      for (int b = 0; b < 2; b++) begin
        c_q[s][b] <= c_q[s-1][b];
        s_q[s][b] <= s_q[s-1][b];
      end
    end
    rej_q[0] <= (hix[0] < lox[1]) || (hix[1] < lox[0]) ||
                (hiy[0] < loy[1]) || (hiy[1] < loy[0]);
    rej_q[1] <= rej_q[0];
    rej_q[2] <= rej_q[1];
    rej_q[3] <= rej_q[2];
    // stage 3..5
    for (int k = 0; k < 4; k++) begin
      for (int b = 0; b < 2; b++) begin
        for (int i = 0; i < 4; i++) begin
          mx_q[k][b][i] <= axx[k] * px_q[b][i];
          my_q[k][b][i] <= axy[k] * py_q[b][i];
          p_q[k][b][i]  <= PW'(mx_q[k][b][i]) + PW'(my_q[k][b][i]);
        end
        mn_q[k][b]  <= mn_d[k][b];
        mxv_q[k][b] <= mx_d[k][b];
      end
    end
    // stage 6
    ovl_q <= !rej_q[3] && !sep;
  end

  assign done_o        = v_q[6];
  assign overlapping_o = ovl_q;

endmodule

// File: rtl/obb_pair_overlap_test_unit.sv
// ----------------------------------------------------------------------------
// obb pair overlap test unit
// separating axis overlap test of two rotated rectangles in fixed point
// ----------------------------------------------------------------------------
// throughput: one beat per cycle, set by the fully pipelined back end
// the receiver cannot stall, so busy stays low in normal operation
// reset: asynchronous, active low, clears all valid flags and the queue
`timescale 1ns / 1ps

module obb_pair_overlap_test_unit #(
  parameter int unsigned TRIG_FRAC_BITS = obb_ovl_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [23:0] center_a_x_i,
  input  logic signed [23:0] center_a_y_i,
  input  logic [23:0]        width_a_i,
  input  logic [23:0]        height_a_i,
  input  logic [12:0]        angle_a_i,
  input  logic signed [23:0] center_b_x_i,
  input  logic signed [23:0] center_b_y_i,
  input  logic [23:0]        width_b_i,
  input  logic [23:0]        height_b_i,
  input  logic [12:0]        angle_b_i,
  output logic               done_o,
  output logic               overlapping_o
);

  // sin/cos width: q(TRIG_FRAC_BITS) plus sign and the value one
  localparam int unsigned TW = TRIG_FRAC_BITS + 2;
  localparam int unsigned GW = $bits(obb_ovl_pkg::box_geo_t);
  localparam int unsigned QW = 2 * GW + 4 * TW;

  obb_ovl_pkg::box_raw_t box [2];
  obb_ovl_pkg::box_geo_t geo_f [2], geo_b [2];
  logic signed [TW-1:0]  cos_f [2], sin_f [2], cos_b [2], sin_b [2];
  obb_ovl_pkg::q_stat_t  q_stat;
  logic                  push;
  logic [QW-1:0]         q_wdata, q_rdata;

  assign box[0] = '{cx: center_a_x_i, cy: center_a_y_i, w: width_a_i,
                    h: height_a_i, ang: angle_a_i};
  assign box[1] = '{cx: center_b_x_i, cy: center_b_y_i, w: width_b_i,
                    h: height_b_i, ang: angle_b_i};

  // front: angle wrap, quadrant fold, sine table and sign fix
  obb_ovl_front #(
    .TrigFracBits(TRIG_FRAC_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .busy_o   (busy),
    .box_i    (box),
    .q_stat_i (q_stat),
    .push_o   (push),
    .geo_o    (geo_f),
    .cos_o    (cos_f),
    .sin_o    (sin_f)
  );

  // one beat per entry: both boxes with their cos and sin
  assign q_wdata = {geo_f[0], geo_f[1], cos_f[0], sin_f[0], cos_f[1], sin_f[1]};

  obb_ovl_queue #(
    .W(QW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (q_wdata),
    .pop_i  (!q_stat.empty),
    .data_o (q_rdata),
    .stat_o (q_stat)
  );

  assign {geo_b[0], geo_b[1], cos_b[0], sin_b[0], cos_b[1], sin_b[1]} = q_rdata;

  // back: corners, bounding box reject, projections, gap test
  obb_ovl_back #(
    .TrigFracBits(TRIG_FRAC_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (!q_stat.empty),
    .geo_i         (geo_b),
    .cos_i         (cos_b),
    .sin_i         (sin_b),
    .done_o        (done_o),
    .overlapping_o (overlapping_o)
  );

endmodule

// File: rtl/obb_ovl_checker.sv
// ----------------------------------------------------------------------------
// obb overlap checker
// port level checks bound onto the overlap test unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "obb_pair_overlap_test_unit_defines.svh"

module obb_ovl_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input logic overlapping_o
);

  // back end never stalls, so the front end never holds off a beat
  `OBB_OVL_ASSERT_IMPL(no_busy_on_start_a, clk_i, rst_ni, start, !busy, "busy while back end free")
  // a result beat carries a defined bit
  `OBB_OVL_ASSERT_IMPL(result_known_a, clk_i, rst_ni, done_o, !$isunknown(overlapping_o), "undefined result")
  // no result beat right after reset release
  `OBB_OVL_ASSERT_IMPL(quiet_after_reset_a, clk_i, rst_ni, $rose(rst_ni), !done_o, "result after reset")

endmodule

bind obb_pair_overlap_test_unit obb_ovl_checker u_obb_ovl_checker (.*);

// File: test/obb_pair_overlap_test_unit_tb.sv
// ----------------------------------------------------------------------------
// obb pair overlap test unit testbench
// drives box pairs through the start/busy port, predicts the overlap bit
// with a local fixed point separating axis model and checks every done beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module obb_pair_overlap_test_unit_tb;

  localparam int unsigned FB = obb_ovl_pkg::TRIG_FRAC_BITS_DEF;
  localparam int NUM_RANDOM = 1600;
  localparam int TAIL_BEATS = 200;        // no idling over the last beats
  localparam int PAUSE_AT = 700;          // sender waits for a drained pipe here
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 30;       // longer than the pipe is deep

  // one box pair beat
  typedef struct {
    logic signed [23:0] cax, cay, cbx, cby;
    logic [23:0]        wa, ha, wb, hb;
    logic [12:0]        aa, ab;
  } pair_beat_t;

  // geometry of one box in q.9, bounding extents in q(9+fb)
  typedef struct {
    longint cx, cy, hx, hy, c, s, ex, ey;
    longint px[4];
    longint py[4];
  } box_geom_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [23:0] center_a_x_i = '0, center_a_y_i = '0;
  logic signed [23:0] center_b_x_i = '0, center_b_y_i = '0;
  logic [23:0] width_a_i = '0, height_a_i = '0, width_b_i = '0, height_b_i = '0;
  logic [12:0] angle_a_i = '0, angle_b_i = '0;
  logic done_o;
  logic overlapping_o;

  pair_beat_t pending_beats[$];
  bit         overlap_expected[$];
  int         beats_sent = 0;
  int         beats_total = 0;
  int         gap_left = 0;
  bit         pause_done = 1'b0;
  bit         failed = 1'b0;
  int         idle_cycles = 0;
  pair_beat_t cur_beat;

  obb_pair_overlap_test_unit uut (
    .clk_i, .rst_ni, .start, .busy,
    .center_a_x_i, .center_a_y_i, .width_a_i, .height_a_i, .angle_a_i,
    .center_b_x_i, .center_b_y_i, .width_b_i, .height_b_i, .angle_b_i,
    .done_o, .overlapping_o
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // overlap predictor
  // ---------------------------------------------------------------------------

  // taylor sine over a quarter wave, r in 1/16 degree, result in q(fb)
  function automatic longint quarter_wave_sine(longint unsigned r);
    longint unsigned x, x2, t, s;
    x  = (r * obb_ovl_pkg::PI_Q30 + 64'd1440) / 64'd2880;
    x2 = (x * x + (64'd1 << 29)) >> 30;
    t  = obb_ovl_pkg::ONE_Q30 - x2 / 110;
    t  = obb_ovl_pkg::ONE_Q30 - ((x2 * t) >> 30) / 72;
    t  = obb_ovl_pkg::ONE_Q30 - ((x2 * t) >> 30) / 42;
    t  = obb_ovl_pkg::ONE_Q30 - ((x2 * t) >> 30) / 20;
    t  = obb_ovl_pkg::ONE_Q30 - ((x2 * t) >> 30) / 6;
    s  = (x * t) >> 30;
    s  = (s + (64'd1 << (29 - FB))) >> (30 - FB);
    if (s > (64'd1 << FB)) s = 64'd1 << FB;
    return longint'(s);
  endfunction

  // full wave sine with wrap at 360 degree
  function automatic longint angle_sine(longint unsigned a);
    longint unsigned q, r;
    a = a % obb_ovl_pkg::FULL_TURN;
    q = a / obb_ovl_pkg::QUARTER_TURN;
    r = a % obb_ovl_pkg::QUARTER_TURN;
    case (q)
      0: return quarter_wave_sine(r);
      1: return quarter_wave_sine(obb_ovl_pkg::QUARTER_TURN - r);
      2: return -quarter_wave_sine(r);
      default: return -quarter_wave_sine(obb_ovl_pkg::QUARTER_TURN - r);
    endcase
  endfunction

  // divide by 2^fb, half away from zero
  function automatic longint round_frac(longint v);
    longint half;
    half = longint'(1) << (FB - 1);
    if (v >= 0) return (v + half) >>> FB;
    return -((-v + half) >>> FB);
  endfunction

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic box_geom_t build_geom(logic signed [23:0] cx, logic signed [23:0] cy,
                                           logic [23:0] w, logic [23:0] h,
                                           logic [12:0] ang);
    box_geom_t g;
    longint ox, oy;
    g.cx = longint'(cx) * 2;
    g.cy = longint'(cy) * 2;
    g.hx = longint'(w);
    g.hy = longint'(h);
    g.s  = angle_sine(longint'(ang));
    g.c  = angle_sine(longint'(ang) + obb_ovl_pkg::QUARTER_TURN);
    // corners walk (-,-) (+,-) (+,+) (-,+)
    for (int i = 0; i < 4; i++) begin
      ox = (i == 0 || i == 3) ? -g.hx : g.hx;
      oy = (i < 2) ? -g.hy : g.hy;
      g.px[i] = g.cx + round_frac(g.c * ox + g.s * oy);
      g.py[i] = g.cy + round_frac(g.c * oy - g.s * ox);
    end
    g.ex = mag(g.c) * g.hx + mag(g.s) * g.hy;
    g.ey = mag(g.s) * g.hx + mag(g.c) * g.hy;
    return g;
  endfunction

  task automatic project_box(input box_geom_t g, input longint ax, input longint ay,
                             output longint mn, output longint mx);
    longint p;
    mn = ax * g.px[0] + ay * g.py[0];
    mx = mn;
    for (int j = 1; j < 4; j++) begin
      p = ax * g.px[j] + ay * g.py[j];
      if (p < mn) mn = p;
      if (p > mx) mx = p;
    end
  endtask

  task automatic predict_overlap(input pair_beat_t b, output bit hit);
    box_geom_t ga, gb;
    longint k, amn, amx, bmn, bmx;
    longint axx[4];
    longint axy[4];
    ga = build_geom(b.cax, b.cay, b.wa, b.ha, b.aa);
    gb = build_geom(b.cbx, b.cby, b.wb, b.hb, b.ab);
    k = longint'(1) << FB;
    hit = 1'b1;
    // axis aligned reject first, touching counts as overlap
    if (ga.cx * k + ga.ex < gb.cx * k - gb.ex || gb.cx * k + gb.ex < ga.cx * k - ga.ex)
      hit = 1'b0;
    if (ga.cy * k + ga.ey < gb.cy * k - gb.ey || gb.cy * k + gb.ey < ga.cy * k - ga.ey)
      hit = 1'b0;
    // separating axes: b, b + 90, a, a + 90
    axx[0] = gb.c;  axy[0] = -gb.s;
    axx[1] = -gb.s; axy[1] = -gb.c;
    axx[2] = ga.c;  axy[2] = -ga.s;
    axx[3] = -ga.s; axy[3] = -ga.c;
    for (int i = 0; i < 4; i++) begin
      project_box(ga, axx[i], axy[i], amn, amx);
      project_box(gb, axx[i], axy[i], bmn, bmx);
      if (amx < bmn || bmx < amn) hit = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  function automatic pair_beat_t mk_beat(int cax, int cay, int wa, int ha, int aa,
                                         int cbx, int cby, int wb, int hb, int ab);
    pair_beat_t b;
    b.cax = 24'(cax); b.cay = 24'(cay); b.wa = 24'(wa); b.ha = 24'(ha); b.aa = 13'(aa);
    b.cbx = 24'(cbx); b.cby = 24'(cby); b.wb = 24'(wb); b.hb = 24'(hb); b.ab = 13'(ab);
    return b;
  endfunction

  // mostly boxes of similar scale near each other, some pure noise
  function automatic pair_beat_t rand_beat();
    pair_beat_t b;
    int span, sz;
    if ($urandom_range(0, 9) == 0) begin
      b.cax = 24'($urandom); b.cay = 24'($urandom);
      b.wa = 24'($urandom); b.ha = 24'($urandom);
      b.cbx = 24'($urandom); b.cby = 24'($urandom);
      b.wb = 24'($urandom); b.hb = 24'($urandom);
      b.aa = 13'($urandom); b.ab = 13'($urandom);
    end else begin
      span = 1 << $urandom_range(6, 22);
      sz = span * 2;
      b.cax = 24'($urandom_range(0, 2 * span) - span);
      b.cay = 24'($urandom_range(0, 2 * span) - span);
      b.cbx = 24'($urandom_range(0, 2 * span) - span);
      b.cby = 24'($urandom_range(0, 2 * span) - span);
      b.wa = 24'($urandom_range(0, sz)); b.ha = 24'($urandom_range(0, sz));
      b.wb = 24'($urandom_range(0, sz)); b.hb = 24'($urandom_range(0, sz));
      // wrapped angles now and then
      b.aa = 13'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191)
                                             : $urandom_range(0, 5759));
      b.ab = 13'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191)
                                             : $urandom_range(0, 5759));
    end
    return b;
  endfunction

  initial begin
    // directed: extremes, quadrant angles, wrap, touching and degenerate boxes
    pending_beats.push_back(mk_beat(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_beats.push_back(mk_beat(0, 0, 256, 256, 0, 256, 0, 256, 256, 0));
    pending_beats.push_back(mk_beat(0, 0, 256, 256, 0, 257, 0, 256, 256, 0));
    pending_beats.push_back(mk_beat(0, 0, 256, 256, 0, 0, 256, 256, 256, 0));
    pending_beats.push_back(mk_beat(0, 0, 1024, 0, 720, 0, 0, 0, 1024, 2160));
    pending_beats.push_back(mk_beat(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_beats.push_back(mk_beat(-8388608, -8388608, 16777215, 16777215, 0,
                                    8388607, 8388607, 16777215, 16777215, 0));
    pending_beats.push_back(mk_beat(-8388608, -8388608, 0, 0, 1440,
                                    8388607, 8388607, 0, 0, 2880));
    pending_beats.push_back(mk_beat(8388607, -8388608, 16777215, 0, 4320,
                                    -8388608, 8388607, 0, 16777215, 5759));
    pending_beats.push_back(mk_beat(0, 0, 4096, 512, 5760, 3000, 0, 4096, 512, 8191));
    pending_beats.push_back(mk_beat(0, 0, 4096, 512, 0, 3000, 0, 4096, 512, 5760));
    pending_beats.push_back(mk_beat(0, 0, 4096, 4096, 720, 4000, 4000, 4096, 4096, 720));
    pending_beats.push_back(mk_beat(0, 0, 4096, 4096, 720, 3000, 0, 1024, 1024, 0));
    pending_beats.push_back(mk_beat(100, 100, 8000, 200, 480, 100, 100, 200, 8000, 4800));
    pending_beats.push_back(mk_beat(0, 0, 16777215, 16777215, 1, 0, 0, 16777215, 16777215,
                                    8190));
    pending_beats.push_back(mk_beat(-1, -1, 1, 1, 1439, 1, 1, 1, 1, 2881));
    pending_beats.push_back(mk_beat(0, 0, 2048, 256, 720, 900, 900, 2048, 256, 2160));
    for (int i = 0; i < NUM_RANDOM; i++) pending_beats.push_back(rand_beat());
    beats_total = pending_beats.size();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_beats.size() == 0 && !start);
    wait (overlap_expected.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (!failed) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // driver: one beat per accepting edge, random gaps, one full drain pause
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    bit hit;
    bit slot_free;
    bit calm;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      slot_free = !start || !busy;
      if (start && !busy) begin
        predict_overlap(cur_beat, hit);
        overlap_expected.push_back(hit);
        beats_sent++;
      end
      if (slot_free) begin
        // alternate stretches with and without gaps, none in the tail
        calm = ((beats_sent / 150) % 3 == 2) || (beats_sent > beats_total - TAIL_BEATS);
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (beats_sent == PAUSE_AT && !pause_done && overlap_expected.size() != 0) begin
          start <= 1'b0;
        end else if (pending_beats.size() != 0) begin
          if (beats_sent == PAUSE_AT) pause_done = 1'b1;
          cur_beat = pending_beats.pop_front();
          center_a_x_i <= cur_beat.cax;
          center_a_y_i <= cur_beat.cay;
          width_a_i    <= cur_beat.wa;
          height_a_i   <= cur_beat.ha;
          angle_a_i    <= cur_beat.aa;
          center_b_x_i <= cur_beat.cbx;
          center_b_y_i <= cur_beat.cby;
          width_b_i    <= cur_beat.wb;
          height_b_i   <= cur_beat.hb;
          angle_b_i    <= cur_beat.ab;
          start <= 1'b1;
          if (!calm && $urandom_range(0, 4) == 0) gap_left = $urandom_range(1, 10);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every done beat is checked against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    bit want;
    if (rst_ni && done_o) begin
      if (overlap_expected.size() == 0) begin
        $error("overlapping: result beat with nothing expected, actual %0d", overlapping_o);
        failed = 1'b1;
      end else begin
        want = overlap_expected.pop_front();
        if (overlapping_o !== want) begin
          $error("overlapping mismatch: expected %0d actual %0d", want, overlapping_o);
          failed = 1'b1;
        end
      end
    end
  end

  // watchdog on cycles where neither side moves a beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

endmodule

// File: obb_pair_overlap_test_unit.f
+incdir+rtl
rtl/obb_ovl_pkg.sv
rtl/obb_ovl_queue.sv
rtl/obb_ovl_front.sv
rtl/obb_ovl_back.sv
rtl/obb_pair_overlap_test_unit.sv
rtl/obb_ovl_checker.sv
test/obb_pair_overlap_test_unit_tb.sv
